### design/sdaq_pkg.sv
// Shared types, constants and codes for the sorted deadline alarm queue.
package sdaq_pkg;

    localparam int NUM_SLOTS_DEF  = 16;
    localparam int TICK_WIDTH_DEF = 32;
    localparam int RATE_W         = 14;
    localparam int SLOT_W         = 4;
    localparam int MS_W           = 32;
    localparam int MUL_W          = MS_W + RATE_W;
    localparam int RECIP_W        = 29;
    localparam int RECIP_SH       = 38;

    localparam logic [RATE_W-1:0]  RATE_RESET = 14'd1000;
    localparam logic [RECIP_W-1:0] MS_RECIP   = 29'd274877907;
    localparam logic [9:0]         HALF_SEC   = 10'd500;
    localparam logic [MUL_W:0]     NS_LIMIT   = 47'd1000000000;

    localparam logic CMD_SET    = 1'b0;
    localparam logic CMD_TICK   = 1'b1;
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_FIRE  = 1'b1;

    typedef struct packed {
        logic              command;
        logic [SLOT_W-1:0] slot_id;
        logic [MS_W-1:0]   delay_ms;
    } in_item_t;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot_out;
        logic [MS_W-1:0]   remaining_ms;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic latch_in;
        logic tick_inc;
        logic rd_slot;
        logic mul_load;
        logic mul_sel_q;
        logic old_clear;
        logic old_load;
        logic div_old;
        logic div_ms;
        logic div_tk;
        logic tdel_load_div;
        logic tdel_load_mul;
        logic wr_dl;
        logic idx_clear;
        logic idx_inc;
        logic remove;
        logic insert;
        logic pop;
        logic load_reply;
        logic load_fire;
        logic fire_last;
    } dp_cmd_t;

    typedef struct packed {
        logic bad_slot;
        logic old_live;
        logic delay_zero;
        logic long_path;
        logic div_done;
        logic scan_end;
        logic scan_hit;
        logic ins_stop;
        logic queue_full;
        logic head_due;
    } dp_status_t;

endpackage

### design/sdaq_div.sv
// Restoring serial divider, one quotient bit per cycle.
module sdaq_div import sdaq_pkg::*; #(
    parameter int ND = 47
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ND-1:0]     numer,
    input  logic [RATE_W-1:0] denom,
    output logic              done,
    output logic [ND-1:0]     quotient
);

    localparam int CW = $clog2(ND + 1);

    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [RATE_W:0]   rem_reg, rem_next;
    logic [ND-1:0]     quo_reg, quo_next;
    logic [RATE_W-1:0] den_reg, den_next;
    logic [RATE_W:0]   rem_sh;
    logic [RATE_W:0]   diff;

    always_comb
    begin
        rem_sh    = {rem_reg[RATE_W-1:0], quo_reg[ND-1]};
        diff      = rem_sh - {1'b0, den_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
            rem_next  = '0;
            quo_next  = numer;
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = diff;
                quo_next = {quo_reg[ND-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[ND-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(ND - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### design/sdaq_datapath.sv
// Datapath: tick counter, deadlines, sorted slot list, arithmetic and result register.
module sdaq_datapath import sdaq_pkg::*; #(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  in_item_t          in_data,
    input  logic              cfg_we,
    input  logic [RATE_W-1:0] cfg_data,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    output out_item_t         out_data
);

    localparam int W  = TICK_WIDTH;
    localparam int SW = $clog2(NUM_SLOTS);
    localparam int LW = $clog2(NUM_SLOTS + 1);
    localparam int ND = (W + 10 > MUL_W + 1) ? W + 10 : MUL_W + 1;
    localparam int PW = MS_W + RECIP_W;
    localparam logic [ND-1:0] TMAX = {{(ND - W + 1){1'b0}}, {(W - 1){1'b1}}};

    in_item_t          item_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [W-1:0]      tick_reg;
    logic [W-1:0]      dl_reg [NUM_SLOTS];
    logic [SW-1:0]     order_reg [NUM_SLOTS];
    logic [LW-1:0]     len_reg;
    logic [LW-1:0]     idx_reg;
    logic [MUL_W-1:0]  mul_reg;
    logic [MS_W-1:0]   old_reg;
    logic [ND-1:0]     tdel_reg;
    logic [W-1:0]      when_reg;
    logic [SW-1:0]     held_reg;
    logic [MS_W-1:0]   q1k_reg;
    out_item_t         out_reg;

    logic [RATE_W-1:0] hz;
    logic              bad;
    logic [SW-1:0]     slot_idx;
    logic [SW-1:0]     idx_rd;
    logic [SW-1:0]     rd_addr;
    logic [W-1:0]      rd_dl;
    logic [W-1:0]      remain;
    logic [ND-1:0]     remain_x;
    logic [MS_W-1:0]   mul_a;
    logic [MUL_W-1:0]  mul_p;
    logic [MS_W-1:0]   q1k_in;
    logic [PW-1:0]     q1k_prod;
    logic              div_start;
    logic [ND-1:0]     div_numer;
    logic [RATE_W-1:0] div_den;
    logic              div_done;
    logic [ND-1:0]     div_quo;
    logic [W-1:0]      tsat;
    logic [W-1:0]      when_sum;
    logic [W-1:0]      when_calc;
    logic [W-1:0]      dl_wdata;

    assign hz       = (rate_reg == '0) ? RATE_W'(1) : rate_reg;
    assign bad      = (32'(item_reg.slot_id) >= NUM_SLOTS);
    assign slot_idx = bad ? '0 : SW'(item_reg.slot_id);
    assign idx_rd   = (32'(idx_reg) < NUM_SLOTS) ? idx_reg[SW-1:0] : '0;
    assign rd_addr  = cmd.rd_slot ? slot_idx : order_reg[idx_rd];
    assign rd_dl    = dl_reg[rd_addr];
    assign remain   = rd_dl - tick_reg;
    assign remain_x = ND'(remain);
    assign mul_a    = cmd.mul_sel_q ? q1k_reg : item_reg.delay_ms;
    assign mul_p    = MUL_W'(mul_a) * MUL_W'(hz);

    // Division by 1000 of a value below 2^32 by reciprocal multiplication.
    // The rounded short-path numerator stays below 2^31 by construction.
    assign q1k_in   = cmd.div_ms ? item_reg.delay_ms : MS_W'(mul_reg) + MS_W'(HALF_SEC);
    assign q1k_prod = PW'(q1k_in) * PW'(MS_RECIP);

    assign div_start = cmd.div_old;
    assign div_numer = (remain_x << 10) - (remain_x << 4) - (remain_x << 3);
    assign div_den   = hz;

    sdaq_div #(.ND(ND)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign tsat      = (tdel_reg > TMAX) ? TMAX[W-1:0] : tdel_reg[W-1:0];
    assign when_sum  = tick_reg + tsat;
    assign when_calc = (when_sum == '0) ? W'(1) : when_sum;
    assign dl_wdata  = (item_reg.delay_ms == '0) ? '0 : when_calc;

    always_comb
    begin
        status.bad_slot   = bad;
        status.old_live   = (rd_dl != '0) && (tick_reg - rd_dl) >> (W - 1) != '0;
        status.delay_zero = (item_reg.delay_ms == '0);
        status.long_path  = ((MUL_W + 1)'(mul_reg) + (MUL_W + 1)'(hz)) > NS_LIMIT;
        status.div_done   = div_done;
        status.scan_end   = (idx_reg == len_reg);
        status.scan_hit   = (order_reg[idx_rd] == slot_idx);
        status.ins_stop   = ((rd_dl - when_reg) >> (W - 1)) == '0;
        status.queue_full = (32'(len_reg) >= NUM_SLOTS);
        status.head_due   = (len_reg != '0) && (((tick_reg - rd_dl) >> (W - 1)) == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RATE_RESET;
            tick_reg <= '0;
            len_reg  <= '0;
            idx_reg  <= '0;
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                dl_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                rate_reg <= cfg_data;
            end
            if (cmd.tick_inc)
            begin
                tick_reg <= tick_reg + 1'b1;
            end
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.remove || cmd.pop)
            begin
                len_reg <= len_reg - 1'b1;
            end
            else if (cmd.insert)
            begin
                len_reg <= len_reg + 1'b1;
            end
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                if (cmd.wr_dl && SW'(k) == slot_idx)
                begin
                    dl_reg[k] <= dl_wdata;
                end
                else if (cmd.pop && SW'(k) == order_reg[idx_rd])
                begin
                    dl_reg[k] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            item_reg <= in_data;
        end
        if (cmd.mul_load)
        begin
            mul_reg <= mul_p;
        end
        if (cmd.div_ms || cmd.div_tk)
        begin
            q1k_reg <= MS_W'(q1k_prod >> RECIP_SH);
        end
        if (cmd.old_clear)
        begin
            old_reg <= '0;
        end
        else if (cmd.old_load)
        begin
            old_reg <= (div_quo > ND'({MS_W{1'b1}})) ? {MS_W{1'b1}} : div_quo[MS_W-1:0];
        end
        if (cmd.tdel_load_div)
        begin
            tdel_reg <= ND'(q1k_reg);
        end
        else if (cmd.tdel_load_mul)
        begin
            tdel_reg <= ND'(mul_reg);
        end
        if (cmd.wr_dl)
        begin
            when_reg <= when_calc;
        end
        if (cmd.pop)
        begin
            held_reg <= order_reg[idx_rd];
        end
        for (int j = 0; j < NUM_SLOTS; j++)
        begin
            if (cmd.remove || cmd.pop)
            begin
                if (j < NUM_SLOTS - 1 && LW'(j) >= idx_reg)
                begin
                    order_reg[j] <= order_reg[(j + 1) % NUM_SLOTS];
                end
            end
            else if (cmd.insert)
            begin
                if (LW'(j) == idx_reg)
                begin
                    order_reg[j] <= slot_idx;
                end
                else if (j > 0 && LW'(j) > idx_reg)
                begin
                    order_reg[j] <= order_reg[(j + NUM_SLOTS - 1) % NUM_SLOTS];
                end
            end
        end
        if (cmd.load_reply)
        begin
            out_reg.kind         <= KIND_REPLY;
            out_reg.slot_out     <= item_reg.slot_id;
            out_reg.remaining_ms <= old_reg;
            out_reg.last         <= 1'b1;
        end
        else if (cmd.load_fire)
        begin
            out_reg.kind         <= KIND_FIRE;
            out_reg.slot_out     <= SLOT_W'(held_reg);
            out_reg.remaining_ms <= '0;
            out_reg.last         <= cmd.fire_last;
        end
    end

    assign out_data = out_reg;

endmodule

### design/sdaq_ctrl.sv
// Controller state machine that sequences set and tick commands.
module sdaq_ctrl import sdaq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_command,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        IDLE, S_CHK, S_OLDW, S_MS, S_MSA, S_MSC, S_MSB, S_WHEN,
        S_RM, S_INS, S_REPLY, T_CHK, T_NEXT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in  = 1'b1;
                    cmd.idx_clear = 1'b1;
                    if (in_command == CMD_TICK)
                    begin
                        cmd.tick_inc = 1'b1;
                        state_next   = T_CHK;
                    end
                    else
                    begin
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                cmd.rd_slot   = 1'b1;
                cmd.mul_load  = 1'b1;
                cmd.old_clear = 1'b1;
                if (status.bad_slot)
                begin
                    state_next = S_REPLY;
                end
                else if (status.old_live)
                begin
                    cmd.div_old = 1'b1;
                    state_next  = S_OLDW;
                end
                else
                begin
                    state_next = S_MS;
                end
            end
            S_OLDW:
            begin
                if (status.div_done)
                begin
                    cmd.old_load = 1'b1;
                    state_next   = S_MS;
                end
            end
            S_MS:
            begin
                if (status.delay_zero)
                begin
                    cmd.wr_dl  = 1'b1;
                    state_next = S_RM;
                end
                else if (status.long_path)
                begin
                    cmd.div_ms = 1'b1;
                    state_next = S_MSA;
                end
                else
                begin
                    cmd.div_tk = 1'b1;
                    state_next = S_MSB;
                end
            end
            S_MSA:
            begin
                cmd.mul_load  = 1'b1;
                cmd.mul_sel_q = 1'b1;
                state_next    = S_MSC;
            end
            S_MSC:
            begin
                cmd.tdel_load_mul = 1'b1;
                state_next        = S_WHEN;
            end
            S_MSB:
            begin
                cmd.tdel_load_div = 1'b1;
                state_next        = S_WHEN;
            end
            S_WHEN:
            begin
                cmd.wr_dl  = 1'b1;
                state_next = S_RM;
            end
            S_RM:
            begin
                if (status.scan_end || status.scan_hit)
                begin
                    cmd.remove    = !status.scan_end;
                    cmd.idx_clear = 1'b1;
                    state_next    = status.delay_zero ? S_REPLY : S_INS;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_INS:
            begin
                if (status.queue_full)
                begin
                    state_next = S_REPLY;
                end
                else if (status.scan_end || status.ins_stop)
                begin
                    cmd.insert = 1'b1;
                    state_next = S_REPLY;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    cmd.load_reply = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            T_CHK:
            begin
                if (status.head_due)
                begin
                    cmd.pop    = 1'b1;
                    state_next = T_NEXT;
                end
                else
                begin
                    state_next = IDLE;
                end
            end
            T_NEXT:
            begin
                if (out_free)
                begin
                    cmd.load_fire  = 1'b1;
                    cmd.fire_last  = !status.head_due;
                    out_valid_next = 1'b1;
                    if (status.head_due)
                    begin
                        cmd.pop = 1'b1;
                    end
                    else
                    begin
                        state_next = IDLE;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### design/sorted_deadline_alarm_queue.sv
// Top level of the sorted deadline alarm queue.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready   in_data   (in_item_t)
//   out       output     out_valid / out_ready out_data  (out_item_t)
//   cfg       input      cfg_we                cfg_data  (tick rate in Hz)
//
// A tick item advances the tick counter, then fires each due alarm from the list head as one result item.
// A set item with a valid slot scans the list once to remove its old entry and, for a
// nonzero delay, once to insert the new one, with one serial divider run if the old alarm is live.
// Reset clears the tick counter, all deadlines and the list length at once.
// A result held in the output register stalls only the next load into it.
module sorted_deadline_alarm_queue import sdaq_pkg::*; #(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_data,
    input  logic              cfg_we,
    input  logic [RATE_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sdaq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_data.command),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .cmd        (cmd)
    );

    sdaq_datapath #(
        .NUM_SLOTS  (NUM_SLOTS),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

### design/sdaq_checker.sv
// Port-level checker for the sorted deadline alarm queue and its bind.
module sdaq_checker import sdaq_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input in_item_t          in_data,
    input logic              out_valid,
    input logic              out_ready,
    input out_item_t         out_data,
    input logic              cfg_we
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_REPLY |-> out_data.last)
        else $error("reply item without last");

    a_fire_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_FIRE |-> out_data.remaining_ms == '0)
        else $error("fired alarm with nonzero remaining time");

    a_set_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.command == CMD_SET |=> !in_ready)
        else $error("set item did not occupy the block");

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> in_ready && !out_valid)
        else $error("rate written while an item was in flight");

endmodule

bind sorted_deadline_alarm_queue sdaq_checker u_sdaq_checker (.*);
